// File: src/tcd_pkg.sv
// Package for the thresholded complex divider: widths, register codes and shared types.
`default_nettype none
package tcd_pkg;

    localparam int DATA_WIDTH    = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COMPLEX_MODE = CFG_IDX_W'(1);

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] num_re;
        logic signed [DATA_WIDTH-1:0] num_im;
        logic signed [DATA_WIDTH-1:0] den_re;
        logic signed [DATA_WIDTH-1:0] den_im;
        logic                         last_in;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] quot_re;
        logic signed [DATA_WIDTH-1:0] quot_im;
        logic                         zeroed;
        logic                         saturated;
        logic                         last_out;
    } out_item_t;

    typedef struct packed {
        logic [2*DATA_WIDTH-1:0] mag;
        logic [2*DATA_WIDTH-1:0] den;
        logic                    neg;
        logic                    clear;
    } lane_in_t;

    typedef struct packed {
        logic valid;
        logic zeroed;
        logic last;
    } side_t;

endpackage
`default_nettype wire

// File: src/tcd_front.sv
// Front end: products, sums, threshold test and divider setup over three stages.
`default_nettype none
module tcd_front
    import tcd_pkg::*;
(
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         adv,
    input  wire logic                         in_valid,
    input  wire in_item_t                     in_data,
    input  wire logic signed [DATA_WIDTH-1:0] threshold,
    input  wire logic                         complex_mode,
    output side_t                             side,
    output lane_in_t                          lane_re,
    output lane_in_t                          lane_im
);
    localparam int PW = 2 * DATA_WIDTH;

    logic v1_reg, last1_reg, mode1_reg, thr_pos1_reg, rzero1_reg;
    logic signed [DATA_WIDTH-1:0] ar1_reg, br1_reg;
    logic signed [PW-1:0] prr_reg, pii_reg, pir_reg, pri_reg, pbr_reg, pbi_reg, ptt_reg;
    logic signed [PW-1:0] prr_next, pii_next, pir_next, pri_next, pbr_next, pbi_next, ptt_next;

    logic v2_reg, last2_reg, mode2_reg, thr_pos2_reg, rzero2_reg;
    logic signed [DATA_WIDTH-1:0] ar2_reg, br2_reg;
    logic signed [PW:0] nre_reg, nim_reg, nre_next, nim_next;
    logic [PW-1:0] mod2_reg, tt_reg, mod2_next, tt_next;

    side_t    side_reg, side_next;
    lane_in_t re_reg, re_next, im_reg, im_next;

    logic signed [PW:0] nre_abs, nim_abs;
    logic [DATA_WIDTH-1:0] ar_mag, br_mag;
    logic czero;

    assign prr_next = in_data.num_re * in_data.den_re;
    assign pii_next = in_data.num_im * in_data.den_im;
    assign pir_next = in_data.num_im * in_data.den_re;
    assign pri_next = in_data.num_re * in_data.den_im;
    assign pbr_next = in_data.den_re * in_data.den_re;
    assign pbi_next = in_data.den_im * in_data.den_im;
    assign ptt_next = threshold * threshold;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            last1_reg    <= in_data.last_in;
            mode1_reg    <= complex_mode;
            thr_pos1_reg <= threshold > 0;
            rzero1_reg   <= in_data.den_re < threshold;
            ar1_reg      <= in_data.num_re;
            br1_reg      <= in_data.den_re;
            prr_reg      <= prr_next;
            pii_reg      <= pii_next;
            pir_reg      <= pir_next;
            pri_reg      <= pri_next;
            pbr_reg      <= pbr_next;
            pbi_reg      <= pbi_next;
            ptt_reg      <= ptt_next;
        end
    end

    assign nre_next  = (PW+1)'(prr_reg) + (PW+1)'(pii_reg);
    assign nim_next  = (PW+1)'(pir_reg) - (PW+1)'(pri_reg);
    assign mod2_next = $unsigned(pbr_reg) + $unsigned(pbi_reg);
    assign tt_next   = $unsigned(ptt_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            last2_reg    <= last1_reg;
            mode2_reg    <= mode1_reg;
            thr_pos2_reg <= thr_pos1_reg;
            rzero2_reg   <= rzero1_reg;
            ar2_reg      <= ar1_reg;
            br2_reg      <= br1_reg;
            nre_reg      <= nre_next;
            nim_reg      <= nim_next;
            mod2_reg     <= mod2_next;
            tt_reg       <= tt_next;
        end
    end

    always_comb begin
        nre_abs = nre_reg[PW] ? -nre_reg : nre_reg;
        nim_abs = nim_reg[PW] ? -nim_reg : nim_reg;
        ar_mag  = ar2_reg[DATA_WIDTH-1] ? $unsigned(-ar2_reg) : $unsigned(ar2_reg);
        br_mag  = br2_reg[DATA_WIDTH-1] ? $unsigned(-br2_reg) : $unsigned(br2_reg);
        czero   = thr_pos2_reg && (mod2_reg < tt_reg);

        side_next.valid = v2_reg;
        side_next.last  = last2_reg;
        if (mode2_reg) begin
            side_next.zeroed = czero;
            re_next.mag   = nre_abs[PW-1:0];
            re_next.den   = mod2_reg;
            re_next.neg   = nre_reg[PW];
            re_next.clear = czero;
            im_next.mag   = nim_abs[PW-1:0];
            im_next.den   = mod2_reg;
            im_next.neg   = nim_reg[PW];
            im_next.clear = czero;
        end else begin
            side_next.zeroed = rzero2_reg;
            re_next.mag   = PW'(ar_mag);
            re_next.den   = PW'(br_mag);
            re_next.neg   = (ar2_reg != '0) && (ar2_reg[DATA_WIDTH-1] ^ br2_reg[DATA_WIDTH-1]);
            re_next.clear = rzero2_reg;
            im_next.mag   = '0;
            im_next.den   = '0;
            im_next.neg   = 1'b0;
            im_next.clear = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= '0;
        end else if (adv) begin
            side_reg <= side_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            re_reg <= re_next;
            im_reg <= im_next;
        end
    end

    assign side    = side_reg;
    assign lane_re = re_reg;
    assign lane_im = im_reg;

endmodule
`default_nettype wire

// File: src/tcd_lane.sv
// Divider lane: overflow check, one restoring quotient bit per stage, saturation.
`default_nettype none
module tcd_lane
    import tcd_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   adv,
    input  wire lane_in_t               din,
    output logic signed [DATA_WIDTH-1:0] quot,
    output logic                        sat
);
    localparam int PW = 2 * DATA_WIDTH;
    localparam int XW = 3 * DATA_WIDTH + FRAC_BITS;

    logic [XW-1:0]         rem_reg [0:DATA_WIDTH];
    logic [XW-1:0]         rem_next [0:DATA_WIDTH-1];
    logic [PW-1:0]         den_reg [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] q_reg   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] q_next  [0:DATA_WIDTH-1];
    logic                  neg_reg [0:DATA_WIDTH];
    logic                  ovf_reg [0:DATA_WIDTH];
    logic                  clr_reg [0:DATA_WIDTH];

    logic [XW-1:0] m0;
    logic [DATA_WIDTH-1:0] limit, q_fin;
    logic signed [DATA_WIDTH-1:0] quot_reg, quot_next;
    logic sat_reg, sat_next, over;

    assign m0 = XW'(din.mag) << FRAC_BITS;

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0] <= m0;
            den_reg[0] <= din.den;
            q_reg[0]   <= '0;
            neg_reg[0] <= din.neg;
            ovf_reg[0] <= m0 >= (XW'(din.den) << DATA_WIDTH);
            clr_reg[0] <= din.clear;
        end
    end

    for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_stage
        localparam int SH = DATA_WIDTH - 1 - k;
        logic [XW-1:0] ds;
        logic          take;

        assign ds   = XW'(den_reg[k]) << SH;
        assign take = rem_reg[k] >= ds;
        assign rem_next[k] = take ? rem_reg[k] - ds : rem_reg[k];
        assign q_next[k]   = q_reg[k] | (DATA_WIDTH'(take) << SH);

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[k+1] <= rem_next[k];
                den_reg[k+1] <= den_reg[k];
                q_reg[k+1]   <= q_next[k];
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
                clr_reg[k+1] <= clr_reg[k];
            end
        end
    end

    always_comb begin
        q_fin = q_reg[DATA_WIDTH];
        limit = neg_reg[DATA_WIDTH] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                                    : {1'b0, {(DATA_WIDTH-1){1'b1}}};
        over  = ovf_reg[DATA_WIDTH] || (q_fin > limit);
        if (clr_reg[DATA_WIDTH]) begin
            quot_next = '0;
            sat_next  = 1'b0;
        end else if (over) begin
            quot_next = $signed(limit);
            sat_next  = 1'b1;
        end else begin
            quot_next = neg_reg[DATA_WIDTH] ? $signed(-q_fin) : $signed(q_fin);
            sat_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            quot_reg <= quot_next;
            sat_reg  <= sat_next;
        end
    end

    assign quot = quot_reg;
    assign sat  = sat_reg;

endmodule
`default_nettype wire

// File: src/thresholded_complex_divider.sv
// Top level of the thresholded complex divider: configuration, pipeline and handshake.
//
//  channel | ports                           | direction | moves
//  --------+---------------------------------+-----------+------------------------
//  s_      | s_valid s_ready s_data          | in        | numerator/denominator
//  m_      | m_valid m_ready m_data          | out       | quotient and flags
//  cfg_    | cfg_we cfg_index cfg_wdata      | in        | register write
//
// One request enters per cycle unless a result is held; each result passes through
// three front stages, the overflow check, one stage per quotient bit and saturation.
// The two divider lanes hold their quotient-bit stages side by side.
// Reset clears the valid bits and loads threshold 0 and complex mode.
// A held result freezes the whole pipeline; s_ready drops only while m_valid waits.
`default_nettype none
module thresholded_complex_divider
    import tcd_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [DATA_WIDTH-1:0] cfg_wdata
);
    localparam int LANE_LAT = DATA_WIDTH + 2;

    logic signed [DATA_WIDTH-1:0] threshold_reg;
    logic                         complex_mode_reg;
    logic                         adv;
    side_t                        fr_side;
    lane_in_t                     fr_re, fr_im;
    side_t                        side_reg [0:LANE_LAT-1];
    logic signed [DATA_WIDTH-1:0] re_quot, im_quot;
    logic                         re_sat, im_sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg    <= '0;
            complex_mode_reg <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_THRESHOLD:    threshold_reg    <= $signed(cfg_wdata);
                REG_COMPLEX_MODE: complex_mode_reg <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    tcd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .in_valid     (s_valid),
        .in_data      (s_data),
        .threshold    (threshold_reg),
        .complex_mode (complex_mode_reg),
        .side         (fr_side),
        .lane_re      (fr_re),
        .lane_im      (fr_im)
    );

    tcd_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_re (
        .aclk (aclk),
        .adv  (adv),
        .din  (fr_re),
        .quot (re_quot),
        .sat  (re_sat)
    );

    tcd_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_im (
        .aclk (aclk),
        .adv  (adv),
        .din  (fr_im),
        .quot (im_quot),
        .sat  (im_sat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg[0] <= '0;
        end else if (adv) begin
            side_reg[0] <= fr_side;
        end
    end

    for (genvar j = 1; j < LANE_LAT; j++) begin : g_side
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                side_reg[j] <= '0;
            end else if (adv) begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    assign m_valid           = side_reg[LANE_LAT-1].valid;
    assign m_data.quot_re    = re_quot;
    assign m_data.quot_im    = im_quot;
    assign m_data.zeroed     = side_reg[LANE_LAT-1].zeroed;
    assign m_data.saturated  = re_sat || im_sat;
    assign m_data.last_out   = side_reg[LANE_LAT-1].last;

endmodule
`default_nettype wire

// File: src/tcd_checker.sv
// Port checker for the thresholded complex divider, bound to the top level.
`default_nettype none
module tcd_checker
    import tcd_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);
    localparam logic signed [DATA_WIDTH-1:0] QMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] QMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    a_zeroed_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.zeroed |->
            m_data.quot_re == '0 && m_data.quot_im == '0 && !m_data.saturated)
        else $error("zeroed result carries data or flag");

    a_sat_extreme: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.saturated |->
            m_data.quot_re == QMAX || m_data.quot_re == QMIN ||
            m_data.quot_im == QMAX || m_data.quot_im == QMIN)
        else $error("saturated result not at a limit");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result stalled");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

endmodule

bind thresholded_complex_divider tcd_checker u_tcd_checker (.*);
`default_nettype wire
